// ===== hw/rtl/utf8_to_ucs2_decoder_macros.svh =====
// assertion macros used by the decoder top level
`ifndef UTF8_TO_UCS2_DECODER_MACROS_SVH
`define UTF8_TO_UCS2_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define U8U2_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define U8U2_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// condition never holds
`define U8U2_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== hw/rtl/u8u2_pkg.sv =====
// package: types and constants of the utf-8 to ucs-2 decoder
package u8u2_pkg;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   localparam logic [7:0] TOP_BIT      = 8'h80;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] LEAD3_MASK   = 8'hF0;
   localparam logic [7:0] LEAD3_CODE   = 8'hE0;
   localparam logic [7:0] LEAD2_LOW    = 8'hC2;
   localparam logic [7:0] LEAD2_HIGH   = 8'hDF;
   localparam logic [7:0] SECOND_SPLIT = 8'hA0;
   localparam logic [11:0] LEAD_E0_BITS = 12'h000;
   localparam logic [11:0] LEAD_ED_BITS = 12'h00D;

   typedef struct packed {
      logic [1:0]  bytes_pending;
      logic [11:0] partial_point;
   } state_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        error;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type result;
   } step_type;

endpackage

// ===== hw/rtl/u8u2_decode.sv =====
// module: one decode step, byte plus state in, next state and result out
module u8u2_decode (
   input  logic [7:0]          byte_in,
   input  logic                end_of_string,
   input  u8u2_pkg::state_type state_cur,
   output u8u2_pkg::state_type state_nxt,
   output u8u2_pkg::step_type  step
);
   import u8u2_pkg::*;

   logic        err;
   logic        emit;
   logic [15:0] unit;
   logic        cont_ok;

   assign cont_ok = ((byte_in & CONT_MASK) == TOP_BIT);

   always_comb begin
      err       = 1'b0;
      emit      = 1'b0;
      unit      = 16'h0000;
      state_nxt = state_cur;
      case (state_cur.bytes_pending)
         PEND_NONE: begin
            if ((byte_in & TOP_BIT) == 8'h00) begin
               unit = {8'h00, byte_in};
               emit = 1'b1;
            end else if (byte_in inside {[LEAD2_LOW:LEAD2_HIGH]}) begin
               state_nxt.partial_point = {7'b0, byte_in[4:0]};
               state_nxt.bytes_pending = PEND_ONE;
            end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
               state_nxt.partial_point = {8'b0, byte_in[3:0]};
               state_nxt.bytes_pending = PEND_TWO;
            end else begin
               err = 1'b1;
            end
         end
         PEND_TWO: begin
            if (!cont_ok) begin
               err = 1'b1;
            end else if (state_cur.partial_point == LEAD_E0_BITS
                         && byte_in < SECOND_SPLIT) begin
               err = 1'b1;   // overlong three-byte form
            end else if (state_cur.partial_point == LEAD_ED_BITS
                         && byte_in >= SECOND_SPLIT) begin
               err = 1'b1;   // surrogate range
            end else begin
               state_nxt.partial_point = {state_cur.partial_point[5:0], byte_in[5:0]};
               state_nxt.bytes_pending = PEND_ONE;
            end
         end
         default: begin
            // one continuation left (unused code 3 acts the same)
            if (!cont_ok) begin
               err = 1'b1;
            end else begin
               unit      = {state_cur.partial_point[9:0], byte_in[5:0]};
               emit      = 1'b1;
               state_nxt = '0;
            end
         end
      endcase

      if (end_of_string && state_nxt.bytes_pending != PEND_NONE) begin
         err = 1'b1;   // truncated sequence
      end
      if (err || end_of_string) begin
         state_nxt = '0;
      end
      if (err) begin
         unit = 16'h0000;
      end
      step.emit             = emit | err | end_of_string;
      step.result.code_unit = unit;
      step.result.error     = err;
      step.result.last      = end_of_string;
   end

endmodule

// ===== hw/rtl/utf8_to_ucs2_decoder.sv =====
// top level: streaming utf-8 to ucs-2 decoder, one byte per word
// accepted bytes sit in the input register; result words reach rsp_ from the result register
// throughput: one byte per cycle unless a stalled word blocks it; decode is combinational
// a byte completing no character, error or end mark yields no word and is consumed silently
// reset (synchronous, active high) empties both stages and clears the decode state
// a held byte that yields a word waits only while a stalled word fills the output register
module utf8_to_ucs2_decoder (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_end_of_string,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_error,
   output logic        rsp_last
);
   `include "utf8_to_ucs2_decoder_macros.svh"
   import u8u2_pkg::*;

   // input register stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eos_ff;

   // decode state carried between bytes
   state_type  state_ff, state_in;

   // result register stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;

   // decode step outputs
   state_type  state_nxt;
   step_type   step;

   logic       out_free;    // result register can take a word this cycle
   logic       s1_fire;     // the held byte finishes its decode step
   logic       req_accept;
   logic       rsp_accept;

   u8u2_decode u_decode (
      .byte_in       (s1_byte_ff),
      .end_of_string (s1_eos_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_nxt),
      .step          (step)
   );

   // output register frees when empty or when its word is taken now
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // a byte with no result never waits on the output side
   assign s1_fire    = s1_valid_ff && (!step.emit || out_free);
   assign req_stall  = s1_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   always_comb begin
      s1_valid_in = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      state_in    = s1_fire ? state_nxt : state_ff;
      if (s1_fire && step.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_byte_in;
         s1_eos_ff  <= req_end_of_string;
      end
      if (s1_fire && step.emit) begin
         rsp_result_ff <= step.result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code_unit = rsp_result_ff.code_unit;
   assign rsp_error     = rsp_result_ff.error;
   assign rsp_last      = rsp_result_ff.last;

   // an error word always carries a zero code unit
   `U8U2_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid_ff && rsp_result_ff.error,
                     rsp_result_ff.code_unit == 16'h0000)
   // the end of a string leaves the decode state cleared
   `U8U2_ASSERT_NEXT(a_eos_clears, clock, reset, s1_fire && s1_eos_ff, state_ff == '0)
   // the pending count never takes its unused code
   `U8U2_ASSERT_NEVER(a_no_pend3, clock, reset, state_ff.bytes_pending == 2'd3)
   // stall toward the source only while a held byte has a word to emit
   `U8U2_ASSERT_IMPL(a_stall_held, clock, reset, req_stall, s1_valid_ff && step.emit)

endmodule

// ===== tb/tb_utf8_to_ucs2_decoder.sv =====
// testbench for the streaming utf-8 to ucs-2 decoder, self-checking against its own predictor
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decoder;
   import u8u2_pkg::*;

   // run ends here no matter what, far above the slowest correct run
   localparam int CYCLE_LIMIT = 200000;
   // cycles to let pass once the last expected word has come
   localparam int SETTLE_CYCLES = 4;

   // how often a side holds off before its next word
   typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_error;
   logic        rsp_last;

   // predictor state: continuation bytes still owed and code point bits so far
   logic [1:0]  pending_conts = PEND_NONE;
   logic [11:0] gathered_bits = '0;

   // words the decoder still owes us, oldest first
   result_type  expected_units[$];

   idle_mode_type sender_mode = IDLE_NONE;
   idle_mode_type receiver_mode = IDLE_NONE;
   int          error_count = 0;
   int          cycle_count = 0;
   int          bytes_sent = 0;

   utf8_to_ucs2_decoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_in       (req_byte_in),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_error         (rsp_error),
      .rsp_last          (rsp_last)
   );

   always #2 clock = ~clock;

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_utf8_to_ucs2_decoder: errors");
         $finish;
      end
   end

   // number of idle cycles a side spends before its next word
   function automatic int draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
         default:   return $urandom_range(0, 18);
      endcase
   endfunction

   // advance the predictor by one accepted byte and queue the word it causes, if any
   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      result_type unit_word;
      logic       emit;
      logic       bad;
      unit_word = '0;
      emit = 1'b0;
      bad = 1'b0;
      if (pending_conts == PEND_NONE) begin
         if ((b & TOP_BIT) == 8'h00) begin
            // plain ascii completes at once
            unit_word.code_unit = {8'h00, b};
            emit = 1'b1;
         end else if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
            gathered_bits = {7'b0, b[4:0]};
            pending_conts = PEND_ONE;
         end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            gathered_bits = {8'b0, b[3:0]};
            pending_conts = PEND_TWO;
         end else begin
            // stray continuation, overlong lead or a form past 16 bits
            bad = 1'b1;
         end
      end else if ((b & CONT_MASK) != TOP_BIT) begin
         bad = 1'b1;
      end else if (pending_conts == PEND_TWO) begin
         // overlong after e0, surrogate range after ed
         if (gathered_bits == LEAD_E0_BITS && b < SECOND_SPLIT) begin
            bad = 1'b1;
         end else if (gathered_bits == LEAD_ED_BITS && b >= SECOND_SPLIT) begin
            bad = 1'b1;
         end else begin
            gathered_bits = {gathered_bits[5:0], b[5:0]};
            pending_conts = PEND_ONE;
         end
      end else begin
         // last continuation, any other pending count behaves like one
         unit_word.code_unit = {gathered_bits[9:0], b[5:0]};
         emit = 1'b1;
         pending_conts = PEND_NONE;
         gathered_bits = '0;
      end

      // character still open at the end mark means truncation
      if (eos && pending_conts != PEND_NONE) bad = 1'b1;
      if (bad) begin
         pending_conts = PEND_NONE;
         gathered_bits = '0;
         emit = 1'b1;
         unit_word.code_unit = '0;
      end
      if (eos) begin
         pending_conts = PEND_NONE;
         gathered_bits = '0;
         emit = 1'b1;
      end
      unit_word.error = bad;
      unit_word.last = eos;
      if (emit) expected_units.push_back(unit_word);
   endfunction

   // offer one byte; entered and left just after a falling edge
   // valid stays high between back-to-back words, it only drops for a real gap
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      gap = draw_wait(sender_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, eos);
      bytes_sent++;
      @(negedge clock);
   endtask

   // encode one code point and send it, optionally broken on the way
   task automatic send_char(input logic [15:0] point, input logic string_end,
                            input logic broken);
      logic [7:0] seq [0:2];
      int         n;
      int         k;
      if (point < 16'h0080) begin
         seq[0] = point[7:0];
         n = 1;
      end else if (point < 16'h0800) begin
         seq[0] = {3'b110, point[10:6]};
         seq[1] = {2'b10, point[5:0]};
         n = 2;
      end else begin
         seq[0] = {4'b1110, point[15:12]};
         seq[1] = {2'b10, point[11:6]};
         seq[2] = {2'b10, point[5:0]};
         n = 3;
      end
      if (broken) begin
         case ($urandom_range(0, 2))
            // cut the character short
            0: if (n > 1) n = $urandom_range(1, n - 1);
            // garble one byte, lead or continuation
            1: seq[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
            // swap the lead for a stray continuation byte
            default: seq[0] = {2'b10, 6'($urandom_range(0, 63))};
         endcase
      end
      for (k = 0; k < n; k++) send_byte(seq[k], string_end && (k == n - 1));
   endtask

   // random code point of a random length class, surrogates left out
   function automatic logic [15:0] draw_point();
      logic [15:0] point;
      case ($urandom_range(0, 2))
         0: point = 16'($urandom_range(16'h0000, 16'h007F));
         1: point = 16'($urandom_range(16'h0080, 16'h07FF));
         default: begin
            point = 16'($urandom_range(16'h0800, 16'hFFFF));
            if (point >= 16'hD800 && point <= 16'hDFFF) point = point ^ 16'h4000;
         end
      endcase
      return point;
   endfunction

   // checker: every accepted word against the oldest expectation
   always @(posedge clock) begin : check_words
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_units.size() == 0) begin
            $error("word with none expected: code_unit %h error %b last %b",
                   rsp_code_unit, rsp_error, rsp_last);
            error_count++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_code_unit !== want.code_unit) begin
               $error("code_unit expected %h actual %h", want.code_unit, rsp_code_unit);
               error_count++;
            end
            if (rsp_error !== want.error) begin
               $error("error expected %b actual %b", want.error, rsp_error);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %b actual %b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // result side: hold stall for a drawn number of cycles, then take one word
   initial begin : receiver
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_wait(receiver_mode);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         @(negedge clock);
      end
   end

   // ascii extremes, one with the end mark
   task automatic test_single_byte();
      sender_mode = IDLE_NONE;
      receiver_mode = IDLE_NONE;
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // smallest and largest two-byte forms
   task automatic test_two_byte();
      sender_mode = IDLE_SOME;
      receiver_mode = IDLE_SOME;
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   // three-byte forms: lowest legal after e0, just below surrogates, ffff at end
   task automatic test_three_byte();
      sender_mode = IDLE_HEAVY;
      receiver_mode = IDLE_NONE;
      send_byte(8'hE0, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hED, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
   endtask

   // stray continuation, overlong lead, four-byte lead, ff with the end mark
   task automatic test_invalid_lead();
      sender_mode = IDLE_NONE;
      receiver_mode = IDLE_HEAVY;
      send_byte(8'h80, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // non-continuation byte, overlong after e0, surrogate after ed
   task automatic test_bad_continuation();
      sender_mode = IDLE_SOME;
      receiver_mode = IDLE_SOME;
      send_byte(8'hC2, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
   endtask

   // end mark with a character still open
   task automatic test_truncation();
      sender_mode = IDLE_NONE;
      receiver_mode = IDLE_NONE;
      send_byte(8'hE1, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hC3, 1'b1);
   endtask

   // mostly well-formed strings, about one character in ten broken
   task automatic test_wellformed_strings(input int byte_goal);
      int len;
      int c;
      while (bytes_sent < byte_goal) begin
         // rotate idling so some strings go through with no gaps at all
         sender_mode = idle_mode_type'($urandom_range(0, 2));
         receiver_mode = idle_mode_type'($urandom_range(0, 2));
         len = $urandom_range(1, 12);
         for (c = 0; c < len; c++)
            send_char(draw_point(), c == len - 1, $urandom_range(0, 9) == 0);
      end
   endtask

   // raw byte noise, weighted toward continuation bytes, end marks now and then
   task automatic test_noise(input int count);
      int i;
      logic [7:0] b;
      sender_mode = IDLE_HEAVY;
      receiver_mode = IDLE_SOME;
      for (i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 1) == 0) b = {2'b10, b[5:0]};
         send_byte(b, $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_byte();
      test_two_byte();
      test_three_byte();
      test_invalid_lead();
      test_bad_continuation();
      test_truncation();
      test_wellformed_strings(bytes_sent + 400);
      test_noise(100);
      // close the last string so it does not stay open
      send_byte(8'h41, 1'b1);

      req_valid <= 1'b0;
      receiver_mode = IDLE_SOME;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_utf8_to_ucs2_decoder: clean");
      end else begin
         $display("tb_utf8_to_ucs2_decoder: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/u8u2_pkg.sv
hw/rtl/u8u2_decode.sv
hw/rtl/utf8_to_ucs2_decoder.sv
tb/tb_utf8_to_ucs2_decoder.sv
